// ----- rtl/pdcd_pkg.sv -----
package pdcd_pkg;

  // Number of receive channels that own a frame decoder.
  localparam int unsigned CHANNELS = 2;
  localparam int unsigned ChanIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned TicksW = 16;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned CsumW  = 3;
  localparam int unsigned PosW   = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TicksW-1:0] LeadMinFirstRst  = 16'd20;
  localparam logic [TicksW-1:0] LeadMinSecondRst = 16'd30;
  localparam logic [TicksW-1:0] LeadMaxRst       = 16'd30000;
  localparam logic [TicksW-1:0] OneThresholdRst  = 16'd3000;
  localparam logic [CmdW-1:0]   ModeRst          = 4'd1;

  // Bit positions loaded when a field starts (MSB first).
  localparam logic [PosW-1:0] CmdFirstPos  = 2'd3;
  localparam logic [PosW-1:0] CsumFirstPos = 2'd2;
  localparam logic [PosW-1:0] LastPos      = 2'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEAD_MIN_FIRST  = 2'd0,
    CFG_LEAD_MIN_SECOND = 2'd1,
    CFG_LEAD_MAX        = 2'd2,
    CFG_ONE_THRESHOLD   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_LEAD     = 2'd1,
    PH_COMMAND  = 2'd2,
    PH_CHECKSUM = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [PosW-1:0] bit_pos;
    logic [CmdW-1:0] cmd;
    logic [CsumW-1:0] csum;
    logic [CsumW-1:0] ones;
  } chan_state_t;

  localparam chan_state_t ChanStateRst = '{
    phase:   PH_IDLE,
    bit_pos: '0,
    cmd:     '0,
    csum:    '0,
    ones:    '0
  };

  typedef struct packed {
    logic [TicksW-1:0] lead_min_first;
    logic [TicksW-1:0] lead_min_second;
    logic [TicksW-1:0] lead_max;
    logic [TicksW-1:0] one_threshold;
  } cfg_t;

  typedef struct packed {
    logic            done;
    logic            ok;
    logic [CmdW-1:0] cmd;
  } step_res_t;

endpackage

// ----- rtl/pulse_distance_command_decoder_unit.sv -----
// Pulse-distance command decoder.
//
// Each input beat reports one falling edge: the receive channel that saw it
// and the timer ticks since the previous edge on any channel. Each channel
// runs its own frame decoder (start edge, lead gap window check, four command
// bits and three checksum bits, MSB first). When a frame closes with a
// checksum equal to the count of one bits in its command, that command
// becomes the shared current mode. Every input beat yields one output beat.
//
// Both channels use valid and stall. An input beat is captured into an input
// register, decoded by a single pass of compare and shift logic, and written
// into the output register with the channel state update in the same cycle.
// Output valid rises when a beat moves from the input register into the output
// register, and the block takes one beat per cycle while the receiver does not
// stall. When the receiver stalls, the output register holds its
// beat and the input register holds the next one; input stall is raised only
// while both are full and the receiver stalls. Configuration writes
// (cfg_ready_o is always high) are expected only while the block is idle.
// Reset clears both pipeline valid bits, all channel decoders to idle, the
// mode to one and the configuration registers to their default values.
module pulse_distance_command_decoder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         channel_i,
  input  logic [pdcd_pkg::TicksW-1:0]  elapsed_ticks_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pdcd_pkg::CmdW-1:0]    current_mode_o,
  output logic                         frame_done_o,
  output logic                         frame_ok_o,
  output logic [pdcd_pkg::CmdW-1:0]    received_command_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pdcd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pdcd_pkg::TicksW-1:0]  cfg_data_i
);
  import pdcd_pkg::*;

  cfg_t cfg_q;

  // Input register.
  logic              in_vld_q;
  logic              chan_q;
  logic [TicksW-1:0] ticks_q;

  // Output register.
  logic            out_vld_q;
  logic [CmdW-1:0] mode_out_q;
  logic            done_q;
  logic            ok_q;
  logic [CmdW-1:0] cmd_q;

  // Decoder state.
  chan_state_t     chan_st_q [CHANNELS];
  logic [CmdW-1:0] mode_q;
  logic [CmdW-1:0] mode_d;

  logic                advance;
  logic                process;
  logic                chan_valid;
  logic [ChanIdxW-1:0] chan_idx;
  chan_state_t         cur_st;
  chan_state_t         nxt_st;
  step_res_t           step_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_min_first  <= LeadMinFirstRst;
      cfg_q.lead_min_second <= LeadMinSecondRst;
      cfg_q.lead_max        <= LeadMaxRst;
      cfg_q.one_threshold   <= OneThresholdRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LEAD_MIN_FIRST:  cfg_q.lead_min_first  <= cfg_data_i;
        CFG_LEAD_MIN_SECOND: cfg_q.lead_min_second <= cfg_data_i;
        CFG_LEAD_MAX:        cfg_q.lead_max        <= cfg_data_i;
        CFG_ONE_THRESHOLD:   cfg_q.one_threshold   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The output register frees up when it is empty or its beat is taken.
  assign advance    = !out_vld_q || !out_stall_i;
  assign process    = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      chan_q  <= channel_i;
      ticks_q <= elapsed_ticks_i;
    end
  end

  // Edges on a channel without a decoder leave all state alone.
  assign chan_valid = 32'(chan_q) < CHANNELS;
  assign chan_idx   = ChanIdxW'(chan_q);
  assign cur_st     = chan_valid ? chan_st_q[chan_idx] : ChanStateRst;

  pdcd_frame_step u_step (
    .cfg_i        (cfg_q),
    .first_chan_i (chan_q == 1'b0),
    .ticks_i      (ticks_q),
    .cur_i        (cur_st),
    .nxt_o        (nxt_st),
    .res_o        (step_res)
  );

  assign mode_d = (chan_valid && step_res.ok) ? step_res.cmd : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_st_q[i] <= ChanStateRst;
      end
      mode_q <= ModeRst;
    end else if (process && chan_valid) begin
      chan_st_q[chan_idx] <= nxt_st;
      mode_q              <= mode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      mode_out_q <= mode_d;
      done_q     <= chan_valid && step_res.done;
      ok_q       <= chan_valid && step_res.ok;
      cmd_q      <= chan_valid ? step_res.cmd : '0;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign current_mode_o     = mode_out_q;
  assign frame_done_o       = done_q;
  assign frame_ok_o         = ok_q;
  assign received_command_o = cmd_q;

endmodule

// ----- rtl/pdcd_frame_step.sv -----
module pdcd_frame_step (
  input  pdcd_pkg::cfg_t              cfg_i,
  input  logic                        first_chan_i,
  input  logic [pdcd_pkg::TicksW-1:0] ticks_i,
  input  pdcd_pkg::chan_state_t       cur_i,
  output pdcd_pkg::chan_state_t       nxt_o,
  output pdcd_pkg::step_res_t         res_o
);
  import pdcd_pkg::*;

  logic              one_bit;
  logic              lead_ok;
  logic [TicksW-1:0] lead_lo;
  logic [CmdW-1:0]   cmd_set;
  logic [CsumW-1:0]  csum_set;
  logic              last_bit;

  assign lead_lo  = first_chan_i ? cfg_i.lead_min_first : cfg_i.lead_min_second;
  assign one_bit  = ticks_i > cfg_i.one_threshold;
  assign lead_ok  = (ticks_i > lead_lo) && (ticks_i < cfg_i.lead_max);
  assign last_bit = cur_i.bit_pos == LastPos;
  assign cmd_set  = one_bit ? CmdW'(4'b0001 << cur_i.bit_pos) : '0;
  assign csum_set = one_bit ? CsumW'(3'b001 << cur_i.bit_pos) : '0;

  // Next decoder state.
  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_IDLE: begin
        nxt_o.phase = PH_LEAD;
      end
      PH_LEAD: begin
        if (lead_ok) begin
          nxt_o.phase   = PH_COMMAND;
          nxt_o.bit_pos = CmdFirstPos;
        end else begin
          nxt_o.phase = PH_IDLE;
        end
      end
      PH_COMMAND: begin
        nxt_o.cmd = cur_i.cmd | cmd_set;
        if (one_bit) begin
          nxt_o.ones = cur_i.ones + CsumW'(1);
        end
        if (last_bit) begin
          nxt_o.phase   = PH_CHECKSUM;
          nxt_o.bit_pos = CsumFirstPos;
        end else begin
          nxt_o.bit_pos = cur_i.bit_pos - PosW'(1);
        end
      end
      PH_CHECKSUM: begin
        nxt_o.csum = cur_i.csum | csum_set;
        if (last_bit) begin
          nxt_o = ChanStateRst;
        end else begin
          nxt_o.bit_pos = cur_i.bit_pos - PosW'(1);
        end
      end
      default: nxt_o = ChanStateRst;
    endcase
  end

  // Result of this edge. The command reported on the closing edge is the
  // finished frame's, before the decoder is cleared.
  always_comb begin
    res_o.done = (cur_i.phase == PH_CHECKSUM) && last_bit;
    res_o.ok   = res_o.done && ((cur_i.csum | csum_set) == cur_i.ones);
    res_o.cmd  = res_o.done ? cur_i.cmd : nxt_o.cmd;
  end

endmodule
